// ===== hdl/scp_pkg.sv =====
// Shared types, codes and the header prefix table for the Set-Cookie parser.
package scp_pkg;

   localparam logic [7:0] CH_NUL  = 8'd0;
   localparam logic [7:0] CH_LF   = 8'd10;
   localparam logic [7:0] CH_CR   = 8'd13;
   localparam logic [7:0] CH_SP   = 8'd32;
   localparam logic [7:0] CH_ZERO = 8'd48;
   localparam logic [7:0] CH_SEMI = 8'd59;
   localparam logic [7:0] CH_EQ   = 8'd61;

   localparam int          PREFIX_LEN  = 11;
   localparam logic [3:0]  PREFIX_LAST = 4'(PREFIX_LEN - 1);

   localparam logic [7:0]  NAME_LIMIT_RST  = 8'd50;
   localparam logic [9:0]  VALUE_LIMIT_RST = 10'd200;

   // register indexes (byte address bit 2)
   localparam logic [0:0]  REG_NAME_LIMIT  = 1'b0;
   localparam logic [0:0]  REG_VALUE_LIMIT = 1'b1;

   typedef enum logic [2:0] {
      PH_WAIT  = 3'd0,
      PH_LINE  = 3'd1,
      PH_FOUND = 3'd2,
      PH_NAME  = 3'd3,
      PH_VALUE = 3'd5,
      PH_END   = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      EV_NAME_BYTE   = 3'd0,
      EV_NAME_END    = 3'd1,
      EV_VALUE_BYTE  = 3'd2,
      EV_COMPLETE    = 3'd3,
      EV_DROP        = 3'd4,
      EV_HEADERS_END = 3'd5
   } event_type;

   typedef struct packed {
      event_type  event_res;
      logic [7:0] payload;
   } result_type;

   typedef struct packed {
      logic [7:0] name_limit;
      logic [9:0] value_limit;
   } limits_type;

   function automatic logic [7:0] prefix_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = "S";
         4'd1:    c = "e";
         4'd2:    c = "t";
         4'd3:    c = "-";
         4'd4:    c = "C";
         4'd5:    c = "o";
         4'd6:    c = "o";
         4'd7:    c = "k";
         4'd8:    c = "i";
         4'd9:    c = "e";
         4'd10:   c = ":";
         default: c = 8'd0;
      endcase
      return c;
   endfunction

   // bytes 128..255 act as signed negatives
   function automatic logic below_space(input logic [7:0] b);
      return (b < CH_SP) || b[7];
   endfunction

endpackage

// ===== hdl/scp_csr.sv =====
// Configuration registers for the name and value length limits.
module scp_csr
   import scp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output limits_type  limits
);

   logic [7:0] name_limit_ff, name_limit_in;
   logic [9:0] value_limit_ff, value_limit_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      name_limit_in  = name_limit_ff;
      value_limit_in = value_limit_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_NAME_LIMIT:  name_limit_in  = pwdata[7:0];
            REG_VALUE_LIMIT: value_limit_in = pwdata[9:0];
            default:         name_limit_in  = name_limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_limit_ff  <= NAME_LIMIT_RST;
         value_limit_ff <= VALUE_LIMIT_RST;
      end else begin
         name_limit_ff  <= name_limit_in;
         value_limit_ff <= value_limit_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_NAME_LIMIT:  prdata = {24'd0, name_limit_ff};
         REG_VALUE_LIMIT: prdata = {22'd0, value_limit_ff};
         default:         prdata = 32'd0;
      endcase
   end

   assign limits.name_limit  = name_limit_ff;
   assign limits.value_limit = value_limit_ff;

endmodule

// ===== hdl/scp_core.sv =====
// Parser state machine: one byte per cycle while go is high, at most one event out.
module scp_core
   import scp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       go,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   input  limits_type limits,
   output logic       ev_valid,
   output result_type ev
);

   phase_type  phase_ff, phase_in, phase_step;
   logic [3:0] match_ff, match_in;
   logic [9:0] len_ff, len_in;
   logic       halted_ff, halted_in;
   logic       is_term;
   logic       name_over, value_over;
   logic       name_ok;

   assign is_term    = below_space(data_byte) || (data_byte == CH_SEMI);
   assign name_over  = len_ff >= {2'd0, limits.name_limit};
   assign value_over = len_ff >= limits.value_limit;
   assign name_ok    = !(data_byte < CH_ZERO || data_byte[7] || data_byte == CH_SEMI);

   // next state
   always_comb begin
      phase_step = phase_ff;
      match_in   = match_ff;
      len_in     = len_ff;
      halted_in  = halted_ff;
      if (go && !halted_ff) begin
         if (data_byte == CH_NUL) begin
            halted_in  = 1'b1;
            phase_step = PH_WAIT;
            match_in   = '0;
            len_in     = '0;
         end else begin
            case (phase_ff)
               PH_LINE: begin
                  if (data_byte == CH_LF) begin
                     phase_step = PH_END;
                     halted_in  = 1'b1;
                  end else if (data_byte == CH_CR) begin
                     phase_step = PH_LINE;
                  end else if (match_ff > PREFIX_LAST ||
                               data_byte != prefix_char(match_ff)) begin
                     match_in   = '0;
                     phase_step = PH_WAIT;
                  end else if (match_ff == PREFIX_LAST) begin
                     match_in   = '0;
                     phase_step = PH_FOUND;
                  end else begin
                     match_in = match_ff + 4'd1;
                  end
               end
               PH_FOUND: begin
                  if (data_byte == CH_SP) begin
                     phase_step = PH_FOUND;
                  end else if (data_byte == CH_LF) begin
                     phase_step = PH_LINE;
                  end else if (!name_ok) begin
                     phase_step = PH_WAIT;
                  end else begin
                     len_in     = 10'd1;
                     phase_step = PH_NAME;
                  end
               end
               PH_NAME: begin
                  if (is_term) begin
                     len_in     = '0;
                     phase_step = (data_byte == CH_LF) ? PH_LINE : PH_WAIT;
                  end else if (data_byte == CH_EQ) begin
                     len_in     = '0;
                     phase_step = PH_VALUE;
                  end else if (name_over) begin
                     len_in     = '0;
                     phase_step = PH_WAIT;
                  end else begin
                     len_in = len_ff + 10'd1;
                  end
               end
               PH_VALUE: begin
                  if (is_term) begin
                     len_in     = '0;
                     phase_step = (data_byte == CH_LF) ? PH_LINE : PH_WAIT;
                  end else if (value_over) begin
                     len_in     = '0;
                     phase_step = PH_WAIT;
                  end else begin
                     len_in = len_ff + 10'd1;
                  end
               end
               PH_END: begin
                  halted_in = 1'b1;
               end
               default: begin
                  phase_step = (data_byte == CH_LF) ? PH_LINE : PH_WAIT;
               end
            endcase
         end
      end
      phase_in = phase_step;
      // buffer end puts the parser back to its start state
      if (go && last_byte) begin
         phase_in  = PH_WAIT;
         match_in  = '0;
         len_in    = '0;
         halted_in = 1'b0;
      end
   end

   // event out
   always_comb begin
      ev_valid     = 1'b0;
      ev.event_res = EV_DROP;
      ev.payload   = 8'd0;
      if (go && !halted_ff) begin
         if (data_byte == CH_NUL) begin
            ev_valid = (phase_ff == PH_NAME) || (phase_ff == PH_VALUE);
         end else begin
            case (phase_ff)
               PH_LINE: begin
                  if (data_byte == CH_LF) begin
                     ev_valid     = 1'b1;
                     ev.event_res = EV_HEADERS_END;
                  end
               end
               PH_FOUND: begin
                  if (data_byte != CH_SP && data_byte != CH_LF && name_ok) begin
                     ev_valid     = 1'b1;
                     ev.event_res = EV_NAME_BYTE;
                     ev.payload   = data_byte;
                  end
               end
               PH_NAME: begin
                  ev_valid = 1'b1;
                  if (is_term) begin
                     ev.event_res = EV_COMPLETE;
                  end else if (data_byte == CH_EQ) begin
                     ev.event_res = EV_NAME_END;
                  end else if (name_over) begin
                     ev.event_res = EV_DROP;
                  end else begin
                     ev.event_res = EV_NAME_BYTE;
                     ev.payload   = data_byte;
                  end
               end
               PH_VALUE: begin
                  ev_valid = 1'b1;
                  if (is_term) begin
                     ev.event_res = EV_COMPLETE;
                  end else if (value_over) begin
                     ev.event_res = EV_DROP;
                  end else begin
                     ev.event_res = EV_VALUE_BYTE;
                     ev.payload   = data_byte;
                  end
               end
               default: begin
                  ev_valid = 1'b0;
               end
            endcase
            // cookie still open at buffer end
            if (last_byte && (phase_step == PH_NAME || phase_step == PH_VALUE)) begin
               ev_valid     = 1'b1;
               ev.event_res = EV_DROP;
               ev.payload   = 8'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         match_ff  <= '0;
         len_ff    <= '0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         match_ff  <= match_in;
         len_ff    <= len_in;
         halted_ff <= halted_in;
      end
   end

endmodule

// ===== hdl/scp_out_fifo.sv =====
// Two-word result buffer that decouples the parser from the result receiver.
module scp_out_fifo
   import scp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       space,
   output logic       pop_valid,
   input  logic       pop_ready,
   output result_type pop_data
);

   result_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign space     = count_ff != 2'd2;
   assign pop_valid = count_ff != 2'd0;
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/set_cookie_header_parser.sv =====
// Top level of the Set-Cookie header parser.
//
// req_* takes response header bytes, one word per byte; req_tlast marks the
// last byte of a buffer, after which the parser starts over (limits kept).
// rsp_* gives zero or one event word per byte: rsp_tuser is the event code,
// rsp_tdata the name or value byte for byte events and zero otherwise.
// csr_* is a register port: name_limit at 0x0, value_limit at 0x4.
//
// Throughput is one byte per cycle while the result buffer has space. A byte
// accepted into the input register is parsed from it once the buffer has
// space; its event is registered into the result buffer and shown on rsp_*.
// The parser state update (prefix match, length count against the limits)
// is the registered loop that sets this rate. A two-word result buffer lets
// parsing go on while the receiver stalls; when it fills, req_tready drops
// once the input register holds a byte, until the receiver takes a word.
// Reset clears parser state and buffer and loads the default limits
// (50 name bytes, 200 value bytes).
module set_cookie_header_parser
   import scp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] payload
   output logic [2:0]  rsp_tuser,   // [2:0] event_res
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       go;
   logic       space;
   logic       ev_valid;
   result_type ev;
   result_type out_word;
   limits_type limits;

   assign go          = in_valid_ff && space;
   assign req_tready  = !in_valid_ff || go;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !go);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   scp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .limits  (limits)
   );

   scp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .limits    (limits),
      .ev_valid  (ev_valid),
      .ev        (ev)
   );

   scp_out_fifo u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_valid),
      .push_data (ev),
      .space     (space),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_data  (out_word)
   );

   assign rsp_tdata = out_word.payload;
   assign rsp_tuser = out_word.event_res;

endmodule

// ===== hdl/scp_checker.sv =====
// Port-level checks for the Set-Cookie parser, bound to the top level.
module scp_checker
   import scp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser,
   input logic       csr_pready
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= EV_HEADERS_END))
      else $error("event code out of range");

   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != EV_NAME_BYTE && rsp_tuser != EV_VALUE_BYTE)
      |-> (rsp_tdata == 8'd0))
      else $error("payload not zero on a non-byte event");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready)
      |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result word changed");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port not ready");

endmodule

bind set_cookie_header_parser scp_checker u_scp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_pready (csr_pready)
);
